>>> src/consensus_election_node_unit_assert.svh
// ---------------------------------------------------------------------------
// consensus_election_node_unit_assert.svh
// Assertion macros shared by the election node RTL.
// ---------------------------------------------------------------------------
`ifndef CONSENSUS_ELECTION_NODE_UNIT_ASSERT_SVH
`define CONSENSUS_ELECTION_NODE_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define CEN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define CEN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cen_pkg.sv
// ---------------------------------------------------------------------------
// cen_pkg
// Types and codes of the consensus election node.
// ---------------------------------------------------------------------------
`default_nettype none

package cen_pkg;

    localparam int MAX_NODES = 8;

    localparam int TERM_W = 32;
    localparam int ID_W   = 3;
    localparam int VOTE_W = 4;
    localparam int CNT_W  = 4;

    // roles
    localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [1:0] ROLE_LEADER    = 2'd2;

    // events
    localparam logic [1:0] ACT_TIMEOUT = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_REPLY   = 2'd2;

    // vote status
    localparam logic [1:0] VS_GRANTED      = 2'd0;
    localparam logic [1:0] VS_REFUSED      = 2'd1;
    localparam logic [1:0] VS_STALE_TERM   = 2'd2;

    // config register indexes
    localparam logic CFG_NODE_ID      = 1'b0;
    localparam logic CFG_CLUSTER_SIZE = 1'b1;

    localparam logic [VOTE_W-1:0] VOTE_NONE = '1;
    localparam logic [TERM_W-1:0] TERM_MAX  = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    typedef struct packed {
        logic [1:0]        role;
        logic [TERM_W-1:0] term;
        logic [VOTE_W-1:0] voted_for;
        logic [CNT_W-1:0]  vote_count;
    } node_state_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [TERM_W-1:0] msg_term;
        logic [ID_W-1:0]   sender_id;
        logic [TERM_W-1:0] peer_last_index;
        logic [TERM_W-1:0] peer_last_term;
        logic              reply_granted;
        logic [TERM_W-1:0] own_last_index;
        logic [TERM_W-1:0] own_last_term;
    } event_t;

    typedef struct packed {
        logic [1:0]        role;
        logic [TERM_W-1:0] current_term;
        logic              start_election;
        logic              vote_given;
        logic [1:0]        vote_status;
        logic              became_leader;
        logic              restart_timer;
    } result_t;

endpackage

`default_nettype wire

>>> src/cen_step.sv
// ---------------------------------------------------------------------------
// cen_step
// Next state and result of the node for one event (combinational).
// ---------------------------------------------------------------------------
`default_nettype none

module cen_step #(
    parameter int MAX_NODES = cen_pkg::MAX_NODES
) (
    input  wire cen_pkg::node_state_t           st,
    input  wire cen_pkg::event_t                ev,
    input  wire logic [cen_pkg::ID_W-1:0]       node_id,
    input  wire logic [3:0]                     cluster_size,
    output cen_pkg::node_state_t                st_next,
    output cen_pkg::result_t                    res
);

    logic                        term_gt;
    logic                        term_lt;
    logic                        log_ok;
    logic [4:0]                  size_eff;
    logic [4:0]                  majority;
    logic [cen_pkg::CNT_W-1:0]   cnt_inc;
    logic [cen_pkg::VOTE_W-1:0]  sender_v;
    cen_pkg::node_state_t        base;

    assign term_gt  = ev.msg_term > st.term;
    assign term_lt  = ev.msg_term < st.term;
    assign log_ok   = (ev.peer_last_term > ev.own_last_term) ||
                      (ev.peer_last_term == ev.own_last_term &&
                       ev.peer_last_index >= ev.own_last_index);
    assign sender_v = {1'b0, ev.sender_id};

    // size 0 counts as 1, clamp at the node limit
    always_comb begin
        if (cluster_size == 4'd0) begin
            size_eff = 5'd1;
        end else if ({1'b0, cluster_size} > 5'(MAX_NODES)) begin
            size_eff = 5'(MAX_NODES);
        end else begin
            size_eff = {1'b0, cluster_size};
        end
    end
    assign majority = (size_eff >> 1) + 5'd1;

    assign cnt_inc = (st.vote_count != cen_pkg::CNT_MAX) ?
                     st.vote_count + cen_pkg::CNT_W'(1) : st.vote_count;

    // state after a higher term has been adopted
    always_comb begin
        base = st;
        if (term_gt) begin
            base.role       = cen_pkg::ROLE_FOLLOWER;
            base.term       = ev.msg_term;
            base.voted_for  = cen_pkg::VOTE_NONE;
            base.vote_count = '0;
        end
    end

    always_comb begin
        st_next = st;
        res     = '0;
        case (ev.action)
            cen_pkg::ACT_TIMEOUT: begin
                if (st.role != cen_pkg::ROLE_LEADER) begin
                    st_next.role = cen_pkg::ROLE_CANDIDATE;
                    if (st.term != cen_pkg::TERM_MAX) begin
                        st_next.term = st.term + cen_pkg::TERM_W'(1);
                    end
                    st_next.voted_for  = {1'b0, node_id};
                    st_next.vote_count = cen_pkg::CNT_W'(1);
                    res.start_election = 1'b1;
                    res.restart_timer  = 1'b1;
                end
            end
            cen_pkg::ACT_REQUEST: begin
                if (term_lt) begin
                    res.vote_status = cen_pkg::VS_STALE_TERM;
                end else begin
                    st_next = base;
                    if (!log_ok) begin
                        res.vote_status = cen_pkg::VS_REFUSED;
                    end else if (base.voted_for != cen_pkg::VOTE_NONE &&
                                 base.voted_for != sender_v) begin
                        res.vote_status = cen_pkg::VS_REFUSED;
                    end else begin
                        st_next.voted_for = sender_v;
                        res.vote_given    = 1'b1;
                        res.vote_status   = cen_pkg::VS_GRANTED;
                        res.restart_timer = 1'b1;
                    end
                end
            end
            cen_pkg::ACT_REPLY: begin
                if (term_gt) begin
                    st_next = base;
                end else if (!term_lt && ev.reply_granted &&
                             st.role == cen_pkg::ROLE_CANDIDATE) begin
                    st_next.vote_count = cnt_inc;
                    // a lone node never wins
                    if (cluster_size > 4'd1 && {1'b0, cnt_inc} >= majority) begin
                        st_next.role      = cen_pkg::ROLE_LEADER;
                        res.became_leader = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.role         = st_next.role;
        res.current_term = st_next.term;
    end

endmodule

`default_nettype wire

>>> src/consensus_election_node_unit.sv
// ---------------------------------------------------------------------------
// consensus_election_node_unit
// Leader election side of one consensus node: role, term, vote and tally.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | tuser: action; tdata: message, peer log, own log
//  m_axis   | out | tdata: role, term, event flags, vote status
//  cfg      | in  | 0 node_id, 1 cluster_size (write only)
//
//  The path runs through an input register, then the result register.
//  One event per cycle while m_tready holds; the state update and the result are formed in the
//  same cycle from the registered event and the node state.
//  A stalled result holds the result register and then the input register;
//  s_tready drops only when both are full.
//  Synchronous active-low reset: follower, term 0, no vote, tally 0.
// ---------------------------------------------------------------------------
`default_nettype none

module consensus_election_node_unit #(
    parameter int MAX_NODES = cen_pkg::MAX_NODES
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] msg_term, [34:32] sender_id, [66:35] peer_last_index,
    // [98:67] peer_last_term, [99] reply_granted, [131:100] own_last_index,
    // [163:132] own_last_term, [167:164] zero
    input  wire logic [167:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [1:0] role, [33:2] current_term, [34] start_election, [35] vote_given,
    // [37:36] vote_status, [38] became_leader, [39] restart_timer
    output logic [39:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [3:0]   cfg_wdata
);

    logic                          in_valid_reg;
    cen_pkg::event_t               in_item_reg;
    logic                          out_valid_reg;
    cen_pkg::result_t              res_reg;
    cen_pkg::node_state_t          st_reg;
    cen_pkg::node_state_t          st_next;
    cen_pkg::result_t              res_next;
    logic [cen_pkg::ID_W-1:0]      node_id_reg;
    logic [3:0]                    cluster_size_reg;
    logic                          advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action          <= s_tuser;
            in_item_reg.msg_term        <= s_tdata[31:0];
            in_item_reg.sender_id       <= s_tdata[34:32];
            in_item_reg.peer_last_index <= s_tdata[66:35];
            in_item_reg.peer_last_term  <= s_tdata[98:67];
            in_item_reg.reply_granted   <= s_tdata[99];
            in_item_reg.own_last_index  <= s_tdata[131:100];
            in_item_reg.own_last_term   <= s_tdata[163:132];
        end
    end

    cen_step #(
        .MAX_NODES    (MAX_NODES)
    ) u_step (
        .st           (st_reg),
        .ev           (in_item_reg),
        .node_id      (node_id_reg),
        .cluster_size (cluster_size_reg),
        .st_next      (st_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.role       <= cen_pkg::ROLE_FOLLOWER;
            st_reg.term       <= '0;
            st_reg.voted_for  <= cen_pkg::VOTE_NONE;
            st_reg.vote_count <= '0;
            out_valid_reg     <= 1'b0;
        end else if (advance) begin
            st_reg        <= st_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg      <= '0;
            cluster_size_reg <= 4'd3;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                cen_pkg::CFG_NODE_ID:      node_id_reg      <= cfg_wdata[2:0];
                cen_pkg::CFG_CLUSTER_SIZE: cluster_size_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.restart_timer, res_reg.became_leader,
                       res_reg.vote_status, res_reg.vote_given,
                       res_reg.start_election, res_reg.current_term,
                       res_reg.role};

`include "consensus_election_node_unit_assert.svh"

    `CEN_ASSERT(a_term_monotonic,
        $past(aresetn) |-> st_reg.term >= $past(st_reg.term),
        "term went backwards")

    `CEN_ASSERT(a_follower_no_tally,
        st_reg.role == cen_pkg::ROLE_FOLLOWER |-> st_reg.vote_count == '0,
        "follower holds a vote tally")

    `CEN_ASSERT(a_leader_announced,
        ($past(aresetn) && st_reg.role == cen_pkg::ROLE_LEADER &&
         $past(st_reg.role) != cen_pkg::ROLE_LEADER) |->
            (out_valid_reg && res_reg.became_leader),
        "leadership taken without became_leader")

    `CEN_ASSERT(a_flags_exclusive,
        out_valid_reg |-> !(res_reg.start_election && res_reg.vote_given),
        "election start and vote grant in one result")

    `CEN_ASSERT_NEXT(a_self_vote,
        advance && res_next.start_election,
        st_reg.role == cen_pkg::ROLE_CANDIDATE &&
            st_reg.voted_for == {1'b0, node_id_reg},
        "election started without self vote")

endmodule

`default_nettype wire
